// ----- hdl/b64d_pkg.sv -----
// Shared types, constants and the alphabet decode function for the
// base64 stream decoder. No dependencies.

package b64d_pkg;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_INVALID    = 2'd1,
      ST_BADPAD     = 2'd2,
      ST_INCOMPLETE = 2'd3
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      status_type status;
      logic       end_of_run;
   } result_type;

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam int         RSP_DEPTH = 4;

   // Returns {invalid, value}; invalid is set for any byte outside the alphabet.
   function automatic logic [6:0] sym_value(input logic [7:0] c);
      logic [6:0] r;
      r = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b0, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b0, 6'd63};
      end
      return r;
   endfunction

endpackage

// ----- hdl/b64d_decode.sv -----
// Per-character decode: quantum state, leftover bits, error and pad tracking,
// and the mode register. Produces up to two results per request.
// Depends on b64d_pkg.

module b64d_decode
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        accept,
   input  logic [7:0]  character,
   input  logic        last,
   output logic [1:0]  push_count,
   output result_type  res0,
   output result_type  res1
);

   logic       padded_mode_ff;
   logic [1:0] qpos_ff, qpos_in;
   logic [5:0] left_ff, left_in;
   status_type err_ff, err_in;
   logic [1:0] pad_ff, pad_in;

   logic [6:0] sym;
   logic       emit;
   logic [7:0] byte_val;
   status_type st;
   result_type data_res, stat_res;

   always_comb begin
      sym      = sym_value(character);
      qpos_in  = qpos_ff;
      left_in  = left_ff;
      err_in   = err_ff;
      pad_in   = pad_ff;
      emit     = 1'b0;
      byte_val = 8'h00;
      if (err_ff == ST_OK) begin
         if (character == PAD_CHAR && padded_mode_ff) begin
            if (pad_ff >= 2'd2) begin
               err_in = ST_BADPAD;
               pad_in = 2'd3;
            end else begin
               pad_in = pad_ff + 2'd1;
            end
         end else if (pad_ff != 2'd0) begin
            err_in = ST_BADPAD;
         end else if (sym[6]) begin
            err_in = ST_INVALID;
         end else begin
            case (qpos_ff)
               2'd0: begin
                  left_in = sym[5:0];
               end
               2'd1: begin
                  emit     = 1'b1;
                  byte_val = {left_ff[5:0], sym[5:4]};
                  left_in  = {2'b00, sym[3:0]};
               end
               2'd2: begin
                  emit     = 1'b1;
                  byte_val = {left_ff[3:0], sym[5:2]};
                  left_in  = {4'b0000, sym[1:0]};
               end
               default: begin
                  emit     = 1'b1;
                  byte_val = {left_ff[1:0], sym[5:0]};
                  left_in  = 6'd0;
               end
            endcase
            qpos_in = qpos_ff + 2'd1;
         end
      end

      st = err_in;
      if (err_in == ST_OK) begin
         if (pad_in == 2'd1) begin
            if (qpos_in != 2'd3) st = ST_BADPAD;
         end else if (pad_in == 2'd2) begin
            if (qpos_in != 2'd2) st = ST_BADPAD;
         end else if (pad_in != 2'd0) begin
            st = ST_BADPAD;
         end else if (qpos_in == 2'd1) begin
            st = ST_INCOMPLETE;
         end
      end

      data_res.kind       = KIND_DATA;
      data_res.data_byte  = byte_val;
      data_res.status     = ST_OK;
      data_res.end_of_run = ~last;

      stat_res.kind       = KIND_STATUS;
      stat_res.data_byte  = 8'h00;
      stat_res.status     = st;
      stat_res.end_of_run = 1'b1;

      res0       = emit ? data_res : stat_res;
      res1       = stat_res;
      push_count = accept ? (2'(emit) + 2'(last)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         padded_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         padded_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpos_ff <= 2'd0;
         left_ff <= 6'd0;
         err_ff  <= ST_OK;
         pad_ff  <= 2'd0;
      end else if (accept) begin
         if (last) begin
            qpos_ff <= 2'd0;
            left_ff <= 6'd0;
            err_ff  <= ST_OK;
            pad_ff  <= 2'd0;
         end else begin
            qpos_ff <= qpos_in;
            left_ff <= left_in;
            err_ff  <= err_in;
            pad_ff  <= pad_in;
         end
      end
   end

   // A string end always leaves a clean state.
   assert property (@(posedge clock) disable iff (reset)
      accept && last |=> qpos_ff == 2'd0 && err_ff == ST_OK && pad_ff == 2'd0)
      else $error("state not cleared after last");

   // Once an error is recorded, the quantum position stays put within the string.
   assert property (@(posedge clock) disable iff (reset)
      accept && !last && err_ff != ST_OK |=> $stable(qpos_ff) && $stable(err_ff))
      else $error("state moved after error");

endmodule

// ----- hdl/b64d_rsp_fifo.sv -----
// Small result queue: takes up to two results per cycle, delivers one while pop_stall is low.
// Depends on b64d_pkg.

module b64d_rsp_fifo
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_count,
   input  result_type  push0,
   input  result_type  push1,
   output logic        almost_full,
   output logic        pop_valid,
   input  logic        pop_stall,
   output result_type  pop_data
);

   localparam int PtrW = $clog2(RSP_DEPTH);
   localparam int CntW = $clog2(RSP_DEPTH + 1);

   result_type      mem_ff [RSP_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign pop         = pop_valid && !pop_stall;
   assign pop_valid   = count_ff != '0;
   assign pop_data    = mem_ff[rd_ptr_ff];
   assign almost_full = count_ff > CntW'(RSP_DEPTH - 2);
   assign count_in    = count_ff + CntW'(push_count) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_ptr_ff + PtrW'(1)] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrW'(push_count);
         rd_ptr_ff <= rd_ptr_ff + PtrW'(pop);
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(RSP_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> !almost_full)
      else $error("push while queue nearly full");

endmodule

// ----- hdl/base64_stream_decoder_core.sv -----
// A character's results are written to the result queue at the edge that takes
// the request; the first is presented on rsp_ in the next cycle if the queue was empty.
// Characters are taken one per cycle while req_stall is low; a character that
// yields a byte and a status at once pushes two results, the queue absorbs the burst.
// Reset: synchronous; clears decode state, queue and padded_mode to 0.
// Top level of the base64 decoder; depends on b64d_pkg, b64d_decode, b64d_rsp_fifo.

module base64_stream_decoder_core
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_run
);

   logic       accept;
   logic [1:0] push_count;
   result_type res0, res1, head;
   logic       almost_full;

   assign req_stall = almost_full;
   assign accept    = req_valid && !req_stall;

   b64d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .character   (req_character),
      .last        (req_last),
      .push_count  (push_count),
      .res0        (res0),
      .res1        (res1)
   );

   b64d_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push0       (res0),
      .push1       (res1),
      .almost_full (almost_full),
      .pop_valid   (rsp_valid),
      .pop_stall   (rsp_stall),
      .pop_data    (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_data_byte  = head.data_byte;
   assign rsp_status     = head.status;
   assign rsp_end_of_run = head.end_of_run;

endmodule
